FILE: rtl/core/wmsd_pkg.sv
// shared widths, types and codes for the window mean and deviation block
package wmsd_pkg;

    // window length limits
    localparam int MAX_SAMPLES = 4096;
    localparam int MIN_SAMPLES = 2;
    localparam int CNT_W       = 13;

    // sample field widths
    localparam int P_W = 17;
    localparam int T_W = 15;
    localparam int H_W = 14;

    // per-sample square widths
    localparam int P_SQ1_W = 34;
    localparam int T_SQ1_W = 29;
    localparam int H_SQ1_W = 28;

    // accumulator widths, sized for a full window of extreme samples
    localparam int PSUM_W = 29;
    localparam int PSQ_W  = 46;
    localparam int TSUM_W = 27;
    localparam int TSQ_W  = 41;
    localparam int HSUM_W = 26;
    localparam int HSQ_W  = 40;

    // sequencer datapath widths
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 46;
    localparam int UNIT_W = 60;
    localparam int M_W    = 24;
    localparam int REM_W  = 25;
    localparam int QUO_W  = 36;
    localparam int ROOT_W = 18;
    localparam int STEP_W = 6;

    // shared unit operation
    typedef enum logic {
        OP_ADD,
        OP_SUB
    } alu_op_t;

    // live window sums seen by the sequencer
    typedef struct packed {
        logic        [PSUM_W-1:0] p_sum;
        logic        [PSQ_W-1:0]  p_sq;
        logic signed [TSUM_W-1:0] t_sum;
        logic        [TSQ_W-1:0]  t_sq;
        logic        [HSUM_W-1:0] h_sum;
        logic        [HSQ_W-1:0]  h_sq;
    } win_t;

    // window close event with the sample count used as n
    typedef struct packed {
        logic             fire;
        logic [CNT_W-1:0] n;
    } close_t;

endpackage

FILE: rtl/core/wmsd_alu.sv
// shared adder-subtractor used by the arithmetic steps of the sequencer
module wmsd_alu (
    input  wmsd_pkg::alu_op_t             op,
    input  logic [wmsd_pkg::UNIT_W-1:0]   a,
    input  logic [wmsd_pkg::UNIT_W-1:0]   b,
    output logic [wmsd_pkg::UNIT_W-1:0]   res,
    output logic                          borrow
);
    import wmsd_pkg::*;

    logic [UNIT_W:0] full;

    // one wide add or subtract, top bit is carry or borrow
    always_comb
    begin
        unique case (op)
            OP_ADD:  full = {1'b0, a} + {1'b0, b};
            OP_SUB:  full = {1'b0, a} - {1'b0, b};
            default: full = '0;
        endcase
    end

    assign res    = full[UNIT_W-1:0];
    assign borrow = full[UNIT_W];

endmodule

FILE: rtl/core/wmsd_accum.sv
// per-channel sum and sum-of-squares accumulators with window counting
module wmsd_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic        [wmsd_pkg::P_W-1:0]    pressure_sample,
    input  logic signed [wmsd_pkg::T_W-1:0]    temperature_sample,
    input  logic        [wmsd_pkg::H_W-1:0]    humidity_sample,
    input  logic        [wmsd_pkg::CNT_W-1:0]  sample_count,
    output logic                               pend,
    output wmsd_pkg::win_t                     win,
    output wmsd_pkg::close_t                   close
);
    import wmsd_pkg::*;

    // registered sample and its squares
    logic        [P_W-1:0]     p_smp_reg;
    logic signed [T_W-1:0]     t_smp_reg;
    logic        [H_W-1:0]     h_smp_reg;
    logic        [P_SQ1_W-1:0] p_sq1_reg;
    logic        [T_SQ1_W-1:0] t_sq1_reg;
    logic        [H_SQ1_W-1:0] h_sq1_reg;

    // accumulators and control
    logic        [PSUM_W-1:0]  p_sum_reg, p_sum_next;
    logic        [PSQ_W-1:0]   p_sq_reg, p_sq_next;
    logic signed [TSUM_W-1:0]  t_sum_reg, t_sum_next;
    logic        [TSQ_W-1:0]   t_sq_reg, t_sq_next;
    logic        [HSUM_W-1:0]  h_sum_reg, h_sum_next;
    logic        [HSQ_W-1:0]   h_sq_reg, h_sq_next;
    logic        [CNT_W-1:0]   taken_reg, taken_next;
    logic                      pend_reg;
    logic                      closed_reg;

    logic        [CNT_W-1:0]   n_eff;
    logic        [CNT_W-1:0]   count;
    logic                      close_now;
    logic        [P_SQ1_W-1:0] p_prod;
    logic signed [2*T_W-1:0]   t_prod;
    logic        [H_SQ1_W-1:0] h_prod;

    // squares of the incoming sample
    assign p_prod = P_SQ1_W'(pressure_sample) * P_SQ1_W'(pressure_sample);
    assign t_prod = (2*T_W)'(temperature_sample) * (2*T_W)'(temperature_sample);
    assign h_prod = H_SQ1_W'(humidity_sample) * H_SQ1_W'(humidity_sample);

    // sample capture on transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_smp_reg <= pressure_sample;
            t_smp_reg <= temperature_sample;
            h_smp_reg <= humidity_sample;
            p_sq1_reg <= p_prod;
            t_sq1_reg <= t_prod[T_SQ1_W-1:0];
            h_sq1_reg <= h_prod;
        end
    end

    // effective window length, clamped to the supported range
    always_comb
    begin
        if (sample_count < CNT_W'(MIN_SAMPLES))
            n_eff = CNT_W'(MIN_SAMPLES);
        else if (sample_count > CNT_W'(MAX_SAMPLES))
            n_eff = CNT_W'(MAX_SAMPLES);
        else
            n_eff = sample_count;
    end

    // accumulate, restarting from zero after a closed window
    always_comb
    begin
        count      = taken_reg + 1'b1;
        close_now  = (count >= n_eff);
        taken_next = close_now ? '0 : count;
        p_sum_next = (closed_reg ? '0 : p_sum_reg) + PSUM_W'(p_smp_reg);
        p_sq_next  = (closed_reg ? '0 : p_sq_reg) + PSQ_W'(p_sq1_reg);
        t_sum_next = (closed_reg ? '0 : t_sum_reg) + TSUM_W'(t_smp_reg);
        t_sq_next  = (closed_reg ? '0 : t_sq_reg) + TSQ_W'(t_sq1_reg);
        h_sum_next = (closed_reg ? '0 : h_sum_reg) + HSUM_W'(h_smp_reg);
        h_sq_next  = (closed_reg ? '0 : h_sq_reg) + HSQ_W'(h_sq1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 1'b0;
            closed_reg <= 1'b0;
            taken_reg  <= '0;
            p_sum_reg  <= '0;
            p_sq_reg   <= '0;
            t_sum_reg  <= '0;
            t_sq_reg   <= '0;
            h_sum_reg  <= '0;
            h_sq_reg   <= '0;
        end
        else if (pend_reg)
        begin
            pend_reg   <= 1'b0;
            closed_reg <= close_now;
            taken_reg  <= taken_next;
            p_sum_reg  <= p_sum_next;
            p_sq_reg   <= p_sq_next;
            t_sum_reg  <= t_sum_next;
            t_sq_reg   <= t_sq_next;
            h_sum_reg  <= h_sum_next;
            h_sq_reg   <= h_sq_next;
        end
        else if (take)
        begin
            pend_reg <= 1'b1;
        end
    end

    // outputs
    assign pend       = pend_reg;
    assign close.fire = pend_reg & close_now;
    assign close.n    = count;
    assign win.p_sum  = p_sum_reg;
    assign win.p_sq   = p_sq_reg;
    assign win.t_sum  = t_sum_reg;
    assign win.t_sq   = t_sq_reg;
    assign win.h_sum  = h_sum_reg;
    assign win.h_sq   = h_sq_reg;

endmodule

FILE: rtl/core/wmsd_seq.sv
// sequencer computing mean and standard deviation per channel on the shared unit
module wmsd_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wmsd_pkg::close_t                  close,
    input  wmsd_pkg::win_t                    win,
    output logic                              busy,
    output logic                              done,
    output logic        [wmsd_pkg::P_W-1:0]   pressure_mean,
    output logic        [wmsd_pkg::P_W-1:0]   pressure_sdev,
    output logic signed [wmsd_pkg::T_W-1:0]   temperature_mean,
    output logic        [wmsd_pkg::H_W-1:0]   temperature_sdev,
    output logic        [wmsd_pkg::H_W-1:0]   humidity_mean,
    output logic        [wmsd_pkg::H_W-1:0]   humidity_sdev
);
    import wmsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MEAN,
        ST_NQ,
        ST_SQ,
        ST_DIFF,
        ST_DIV,
        ST_ROOT
    } state_t;

    localparam logic [1:0] CH_PRES = 2'd0;
    localparam logic [1:0] CH_TEMP = 2'd1;
    localparam logic [1:0] CH_HUM  = 2'd2;

    state_t                   state_reg;
    logic        [1:0]        ch_reg;
    logic        [STEP_W-1:0] cnt_reg;
    logic        [CNT_W-1:0]  n_reg;
    logic        [M_W-1:0]    m_reg;
    logic        [MAG_W-1:0]  s_reg;
    logic                     neg_reg;
    logic        [SQ_W-1:0]   q_reg;
    logic        [UNIT_W-1:0] acc_reg;
    logic        [UNIT_W-1:0] aux_reg;
    logic        [REM_W-1:0]  rem_reg;
    logic        [QUO_W-1:0]  quo_reg;
    logic        [ROOT_W-1:0] root_reg;
    logic                     done_reg;
    logic        [P_W-1:0]    mean_p_reg;
    logic        [P_W-1:0]    std_p_reg;
    logic signed [T_W-1:0]    mean_t_reg;
    logic        [H_W-1:0]    std_t_reg;
    logic        [H_W-1:0]    mean_h_reg;
    logic        [H_W-1:0]    std_h_reg;

    alu_op_t                  alu_op;
    logic        [UNIT_W-1:0] alu_a;
    logic        [UNIT_W-1:0] alu_b;
    logic        [UNIT_W-1:0] alu_res;
    logic                     alu_borrow;

    logic                     s_bit;
    logic                     n_bit;
    logic        [MAG_W-1:0]  ld_s;
    logic                     ld_neg;
    logic        [SQ_W-1:0]   ld_q;
    logic        [TSUM_W-1:0] t_abs;
    logic        [QUO_W-1:0]  quo_fin;
    logic        [ROOT_W-1:0] root_fin;
    logic        [T_W-1:0]    t_mean;

    wmsd_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign s_bit = s_reg[cnt_reg[4:0]];
    assign n_bit = n_reg[cnt_reg[3:0]];

    // channel operand select
    assign t_abs = win.t_sum[TSUM_W-1] ? (~win.t_sum + 1'b1) : win.t_sum;

    always_comb
    begin
        unique case (ch_reg)
            CH_PRES:
            begin
                ld_s   = MAG_W'(win.p_sum);
                ld_neg = 1'b0;
                ld_q   = SQ_W'(win.p_sq);
            end
            CH_TEMP:
            begin
                ld_s   = MAG_W'(t_abs);
                ld_neg = win.t_sum[TSUM_W-1];
                ld_q   = SQ_W'(win.t_sq);
            end
            CH_HUM:
            begin
                ld_s   = MAG_W'(win.h_sum);
                ld_neg = 1'b0;
                ld_q   = SQ_W'(win.h_sq);
            end
            default:
            begin
                ld_s   = '0;
                ld_neg = 1'b0;
                ld_q   = '0;
            end
        endcase
    end

    // shared unit operands per step
    always_comb
    begin
        alu_op = OP_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_MEAN:
            begin
                alu_op = OP_SUB;
                alu_a  = UNIT_W'({rem_reg[CNT_W-1:0], s_bit});
                alu_b  = UNIT_W'(n_reg);
            end
            ST_NQ:
            begin
                alu_a = {acc_reg[UNIT_W-2:0], 1'b0};
                alu_b = n_bit ? UNIT_W'(q_reg) : '0;
            end
            ST_SQ:
            begin
                alu_a = {aux_reg[UNIT_W-2:0], 1'b0};
                alu_b = s_bit ? UNIT_W'(s_reg) : '0;
            end
            ST_DIFF:
            begin
                alu_op = OP_SUB;
                alu_a  = acc_reg;
                alu_b  = aux_reg;
            end
            ST_DIV:
            begin
                alu_op = OP_SUB;
                alu_a  = UNIT_W'({rem_reg[M_W-1:0], acc_reg[UNIT_W-1]});
                alu_b  = UNIT_W'(m_reg);
            end
            ST_ROOT:
            begin
                alu_op = OP_SUB;
                alu_a  = UNIT_W'({rem_reg[ROOT_W:0], quo_reg[QUO_W-1 -: 2]});
                alu_b  = UNIT_W'({root_reg, 2'b01});
            end
            default:
            begin
                alu_op = OP_ADD;
            end
        endcase
    end

    // final quotient and root bits of the current step
    assign quo_fin  = {quo_reg[QUO_W-2:0], ~alu_borrow};
    assign root_fin = {root_reg[ROOT_W-2:0], ~alu_borrow};
    assign t_mean   = neg_reg ? (~quo_fin[T_W-1:0] + 1'b1) : quo_fin[T_W-1:0];

    // sequencer with datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_reg     <= CH_PRES;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            n_reg      <= '0;
            m_reg      <= '0;
            s_reg      <= '0;
            neg_reg    <= 1'b0;
            q_reg      <= '0;
            acc_reg    <= '0;
            aux_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            root_reg   <= '0;
            mean_p_reg <= '0;
            std_p_reg  <= '0;
            mean_t_reg <= '0;
            std_t_reg  <= '0;
            mean_h_reg <= '0;
            std_h_reg  <= '0;
        end
        else
        begin
            // strobe with the last root step of the last channel
            done_reg <= (state_reg == ST_ROOT) && (cnt_reg == '0) && (ch_reg == CH_HUM);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (close.fire)
                    begin
                        n_reg     <= close.n;
                        m_reg     <= M_W'(M_W'(close.n) * M_W'(close.n - 1'b1));
                        ch_reg    <= CH_PRES;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    s_reg     <= ld_s;
                    neg_reg   <= ld_neg;
                    q_reg     <= ld_q;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= STEP_W'(MAG_W - 1);
                    state_reg <= ST_MEAN;
                end
                // restoring division of the sum magnitude by n
                ST_MEAN:
                begin
                    rem_reg <= alu_borrow ? alu_a[REM_W-1:0] : alu_res[REM_W-1:0];
                    quo_reg <= quo_fin;
                    if (cnt_reg == '0)
                    begin
                        unique case (ch_reg)
                            CH_PRES: mean_p_reg <= quo_fin[P_W-1:0];
                            CH_TEMP: mean_t_reg <= t_mean;
                            CH_HUM:  mean_h_reg <= quo_fin[H_W-1:0];
                            default: mean_h_reg <= mean_h_reg;
                        endcase
                        acc_reg   <= '0;
                        cnt_reg   <= STEP_W'(CNT_W - 1);
                        state_reg <= ST_NQ;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                // n times sum of squares, msb first
                ST_NQ:
                begin
                    acc_reg <= alu_res;
                    if (cnt_reg == '0)
                    begin
                        aux_reg   <= '0;
                        cnt_reg   <= STEP_W'(MAG_W - 1);
                        state_reg <= ST_SQ;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                // square of the sum magnitude, msb first
                ST_SQ:
                begin
                    aux_reg <= alu_res;
                    if (cnt_reg == '0)
                        state_reg <= ST_DIFF;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_DIFF:
                begin
                    acc_reg   <= alu_res;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= STEP_W'(UNIT_W - 1);
                    state_reg <= ST_DIV;
                end
                // restoring division by n(n-1)
                ST_DIV:
                begin
                    acc_reg <= {acc_reg[UNIT_W-2:0], 1'b0};
                    quo_reg <= quo_fin;
                    if (cnt_reg == '0)
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= STEP_W'(ROOT_W - 1);
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        rem_reg <= alu_borrow ? alu_a[REM_W-1:0] : alu_res[REM_W-1:0];
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                // digit-by-digit integer square root, two bits a step
                ST_ROOT:
                begin
                    quo_reg  <= {quo_reg[QUO_W-3:0], 2'b00};
                    rem_reg  <= alu_borrow ? alu_a[REM_W-1:0] : alu_res[REM_W-1:0];
                    root_reg <= root_fin;
                    if (cnt_reg == '0)
                    begin
                        unique case (ch_reg)
                            CH_PRES: std_p_reg <= root_fin[ROOT_W-1] ? '1 : root_fin[P_W-1:0];
                            CH_TEMP: std_t_reg <= (|root_fin[ROOT_W-1:H_W]) ? '1
                                                                            : root_fin[H_W-1:0];
                            CH_HUM:  std_h_reg <= (|root_fin[ROOT_W-1:H_W]) ? '1
                                                                            : root_fin[H_W-1:0];
                            default: std_h_reg <= std_h_reg;
                        endcase
                        if (ch_reg == CH_HUM)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_LOAD;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign pressure_mean    = mean_p_reg;
    assign pressure_sdev    = std_p_reg;
    assign temperature_mean = mean_t_reg;
    assign temperature_sdev = std_t_reg;
    assign humidity_mean    = mean_h_reg;
    assign humidity_sdev    = std_h_reg;

    // a window only closes while the sequencer is free
    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        close.fire |-> state_reg == ST_IDLE)
        else $error("window closed while sequencer busy");

    // n times sum of squares never falls below the squared sum
    a_diff_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIFF |-> !alu_borrow)
        else $error("negative squared deviation");

    // result strobe follows the last root step and lasts one cycle
    a_done_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_ROOT) && state_reg == ST_IDLE)
        else $error("result strobe out of sequence");

    // channel index stays within the three channels
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> ch_reg == CH_PRES || ch_reg == CH_TEMP || ch_reg == CH_HUM)
        else $error("channel index out of range");

endmodule

FILE: rtl/core/window_mean_stddev_three_channel.sv
// top level of the three-channel window mean and standard deviation block
// Each sample transfer (start high while busy is low) keeps busy high while the sample
// is added to the channel sums, so the next sample can only be taken once that is done.
// The sample that completes a window instead keeps busy high until its result: done
// pulses for one cycle, and busy is already low in that cycle. After the accumulate step
// the sequencer makes three passes, one per channel, each of 153 steps on a single
// 60-bit adder-subtractor: a load step, a 30-step division for the mean, 13 and 30
// shift-add steps for n times the sum of squares and the squared sum, one subtract,
// a 60-step division by n(n-1) and an 18-step square root.
// The result ports are valid only while done is high and the receiver must take them in
// that cycle. Writing sample_count takes effect from the next sample on.
module window_mean_stddev_three_channel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              sample_count_we,
    input  logic        [wmsd_pkg::CNT_W-1:0] sample_count,
    input  logic        [wmsd_pkg::P_W-1:0]   pressure_sample,
    input  logic signed [wmsd_pkg::T_W-1:0]   temperature_sample,
    input  logic        [wmsd_pkg::H_W-1:0]   humidity_sample,
    output logic                              done,
    output logic        [wmsd_pkg::P_W-1:0]   pressure_mean,
    output logic        [wmsd_pkg::P_W-1:0]   pressure_sdev,
    output logic signed [wmsd_pkg::T_W-1:0]   temperature_mean,
    output logic        [wmsd_pkg::H_W-1:0]   temperature_sdev,
    output logic        [wmsd_pkg::H_W-1:0]   humidity_mean,
    output logic        [wmsd_pkg::H_W-1:0]   humidity_sdev
);
    import wmsd_pkg::*;

    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(16);

    logic [CNT_W-1:0] sample_count_reg;
    logic             take;
    logic             accum_pend;
    logic             seq_busy;
    win_t             win;
    close_t           close;

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_count_reg <= SAMPLE_COUNT_RST;
        else if (sample_count_we)
            sample_count_reg <= sample_count;
    end

    // sample transfer
    assign take = start & ~busy;
    assign busy = accum_pend | seq_busy;

    wmsd_accum u_accum (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (take),
        .pressure_sample    (pressure_sample),
        .temperature_sample (temperature_sample),
        .humidity_sample    (humidity_sample),
        .sample_count       (sample_count_reg),
        .pend               (accum_pend),
        .win                (win),
        .close              (close)
    );

    wmsd_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .close            (close),
        .win              (win),
        .busy             (seq_busy),
        .done             (done),
        .pressure_mean    (pressure_mean),
        .pressure_sdev    (pressure_sdev),
        .temperature_mean (temperature_mean),
        .temperature_sdev (temperature_sdev),
        .humidity_mean    (humidity_mean),
        .humidity_sdev    (humidity_sdev)
    );

endmodule
